@@ sv/hcb_pkg.sv @@
// Shared constants and types for the histogram clip bounds block.
package hcb_pkg;

  localparam int MAX_BINS   = 256;
  localparam int COUNT_BITS = 24;
  localparam int ADDR_W     = $clog2(MAX_BINS);
  localparam int NUM_W      = $clog2(MAX_BINS + 1);
  localparam int TOTAL_W    = COUNT_BITS + ADDR_W;
  localparam int FRAC_W     = 16;
  localparam int THR_W      = FRAC_W + 1;
  localparam int PROD_W     = TOTAL_W + THR_W;

  localparam logic [FRAC_W-1:0] CLIP_RESET = FRAC_W'(655);
  localparam logic [THR_W-1:0]  ONE_Q16    = THR_W'(1) << FRAC_W;

  typedef struct packed {
    logic clear;
    logic step;
    logic first;
  } scan_ctrl_t;

  typedef struct packed {
    logic              found;
    logic [ADDR_W-1:0] idx;
    logic              zero;
  } scan_res_t;

endpackage

@@ sv/hcb_ram.sv @@
// Generic single-write, single-read synchronous RAM with registered read data.
module hcb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     wr_en_i,
  input  logic [$clog2(DEPTH)-1:0] wr_addr_i,
  input  logic [WIDTH-1:0]         wr_data_i,
  input  logic                     rd_en_i,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_i,
  output logic [WIDTH-1:0]         rd_data_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_o <= mem_q[rd_addr_i];
    end
  end

endmodule

@@ sv/hcb_scan.sv @@
// One threshold scan: running sum over streamed bins and first flip of the test.
module hcb_scan import hcb_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  scan_ctrl_t            ctrl_i,
  input  logic [COUNT_BITS-1:0] bin_i,
  input  logic [ADDR_W-1:0]     idx_i,
  input  logic [THR_W-1:0]      thr_i,
  input  logic [TOTAL_W-1:0]    total_i,
  output scan_res_t             res_o
);

  logic [PROD_W-1:0]  rhs_q;
  logic               zero_q;
  logic [TOTAL_W-1:0] sum_q, sum_d;
  logic               prev_q, cur;
  logic               found_q;
  logic [ADDR_W-1:0]  idx_q;

  assign sum_d = (ctrl_i.first ? '0 : sum_q) + TOTAL_W'(bin_i);
  assign cur   = PROD_W'({sum_d, FRAC_W'(0)}) >= rhs_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      found_q <= 1'b0;
      prev_q  <= 1'b0;
    end else if (ctrl_i.clear) begin
      found_q <= 1'b0;
    end else if (ctrl_i.step) begin
      prev_q <= cur;
      if (!ctrl_i.first && !found_q && (cur != prev_q)) begin
        found_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.clear) begin
      rhs_q  <= PROD_W'(thr_i) * PROD_W'(total_i);
      zero_q <= (total_i == '0);
    end
    if (ctrl_i.step) begin
      sum_q <= sum_d;
      if (!ctrl_i.first && !found_q && (cur != prev_q)) begin
        idx_q <= idx_i;
      end
    end
  end

  assign res_o.found = found_q && !zero_q;
  assign res_o.idx   = idx_q;
  assign res_o.zero  = zero_q;

  a_found_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    found_q && !ctrl_i.clear |=> found_q)
    else $error("scan crossing flag dropped without clear");

  a_found_needs_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !found_q ##1 found_q |-> $past(ctrl_i.step) && !$past(ctrl_i.first))
    else $error("scan crossing recorded outside a scan step");

  a_clear_drops_found: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_i.clear |=> !found_q)
    else $error("scan crossing flag kept across clear");

endmodule

@@ sv/histogram_clip_bounds_top.sv @@
// Top level of the histogram clip bounds block: bin store, control and result register.
// Input: bins transfer one per cycle while the block is in its load state; after the last bin the
//   block steps through prepare, setup, a scan over the N bins stored (up to 256) and finish.
// Scan: bins of the next histogram are not taken until the result of this one is registered;
//   the scan rate of one bin per cycle is set by the single read port of the bin store.
// Reset: asynchronous, active low; clears counters, control and clip to 655.
module histogram_clip_bounds_top import hcb_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [23:0] bin_count_i,
  input  logic        last_bin_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [7:0]  low_bin_o,
  output logic [8:0]  high_bin_o,
  output logic [8:0]  bins_loaded_o,
  output logic        empty_flag_o,
  output logic        overflow_flag_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [15:0] clip_fraction_i
);

  localparam logic [2:0] ST_LOAD   = 3'd0;
  localparam logic [2:0] ST_PREP   = 3'd1;
  localparam logic [2:0] ST_SETUP  = 3'd2;
  localparam logic [2:0] ST_SCAN   = 3'd3;
  localparam logic [2:0] ST_FINISH = 3'd4;

  logic [2:0]            state_q, state_d;
  logic [FRAC_W-1:0]     clip_q;
  logic [NUM_W-1:0]      bins_seen_q;
  logic                  overflow_q;
  logic [TOTAL_W-1:0]    total_q;
  logic [COUNT_BITS-1:0] first_q, lastv_q;
  logic [TOTAL_W-1:0]    tl_q, th_q;
  logic [ADDR_W-1:0]     scan_idx_q;
  logic                  out_valid_q;
  logic [7:0]            low_q;
  logic [8:0]            high_q, loaded_q;
  logic                  empty_q, ovf_q;

  logic                  in_xfer, store_bin, last_el, out_free;
  logic [COUNT_BITS-1:0] cnt, rd_data, lo_bin, hi_bin;
  logic                  rd_en;
  logic [ADDR_W-1:0]     rd_addr;
  scan_ctrl_t            ctrl;
  scan_res_t             lo_res, hi_res;
  logic [NUM_W-1:0]      hi_num;

  assign cnt         = bin_count_i[COUNT_BITS-1:0];
  assign in_ready_o  = (state_q == ST_LOAD);
  assign in_xfer     = in_valid_i && in_ready_o;
  assign store_bin   = in_xfer && (bins_seen_q < NUM_W'(MAX_BINS));
  assign cfg_ready_o = 1'b1;
  assign last_el     = ({1'b0, scan_idx_q} == (bins_seen_q - NUM_W'(1)));
  assign out_free    = !out_valid_q || out_ready_i;

  assign ctrl.clear = (state_q == ST_SETUP);
  assign ctrl.step  = (state_q == ST_SCAN);
  assign ctrl.first = (scan_idx_q == '0);

  assign rd_en   = (state_q == ST_SETUP) || (state_q == ST_SCAN);
  assign rd_addr = (state_q == ST_SETUP) ? '0 : scan_idx_q + ADDR_W'(1);
  assign lo_bin  = (scan_idx_q == '0) ? '0 : rd_data;
  assign hi_bin  = last_el ? '0 : rd_data;
  assign hi_num  = (hi_res.found ? NUM_W'(hi_res.idx) : '0) + NUM_W'(1);

  hcb_ram #(
    .WIDTH(COUNT_BITS),
    .DEPTH(MAX_BINS)
  ) u_store (
    .clk_i    (clk_i),
    .wr_en_i  (store_bin),
    .wr_addr_i(bins_seen_q[ADDR_W-1:0]),
    .wr_data_i(cnt),
    .rd_en_i  (rd_en),
    .rd_addr_i(rd_addr),
    .rd_data_o(rd_data)
  );

  hcb_scan u_scan_lo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (ctrl),
    .bin_i  (lo_bin),
    .idx_i  (scan_idx_q),
    .thr_i  (THR_W'(clip_q)),
    .total_i(tl_q),
    .res_o  (lo_res)
  );

  hcb_scan u_scan_hi (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (ctrl),
    .bin_i  (hi_bin),
    .idx_i  (scan_idx_q),
    .thr_i  (ONE_Q16 - THR_W'(clip_q)),
    .total_i(th_q),
    .res_o  (hi_res)
  );

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_LOAD:   if (in_xfer && last_bin_i) state_d = ST_PREP;
      ST_PREP:   state_d = ST_SETUP;
      ST_SETUP:  state_d = ST_SCAN;
      ST_SCAN:   if (last_el) state_d = ST_FINISH;
      ST_FINISH: if (out_free) state_d = ST_LOAD;
      default:   state_d = ST_LOAD;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_LOAD;
      clip_q      <= CLIP_RESET;
      bins_seen_q <= '0;
      overflow_q  <= 1'b0;
      total_q     <= '0;
      scan_idx_q  <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_valid_i) begin
        clip_q <= clip_fraction_i;
      end
      if (store_bin) begin
        bins_seen_q <= bins_seen_q + NUM_W'(1);
        total_q     <= total_q + TOTAL_W'(cnt);
      end else if (in_xfer) begin
        overflow_q <= 1'b1;
      end
      if (state_q == ST_SETUP) begin
        scan_idx_q <= '0;
      end else if (state_q == ST_SCAN && !last_el) begin
        scan_idx_q <= scan_idx_q + ADDR_W'(1);
      end
      if (state_q == ST_FINISH && out_free) begin
        out_valid_q <= 1'b1;
        bins_seen_q <= '0;
        overflow_q  <= 1'b0;
        total_q     <= '0;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (store_bin) begin
      lastv_q <= cnt;
      if (bins_seen_q == '0) begin
        first_q <= cnt;
      end
    end
    if (state_q == ST_PREP) begin
      tl_q <= total_q - TOTAL_W'(first_q);
      th_q <= total_q - TOTAL_W'(lastv_q);
    end
    if (state_q == ST_FINISH && out_free) begin
      low_q    <= 8'(lo_res.found ? lo_res.idx - ADDR_W'(1) : '0);
      high_q   <= 9'(hi_num);
      loaded_q <= 9'(bins_seen_q);
      empty_q  <= lo_res.zero || hi_res.zero;
      ovf_q    <= overflow_q;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign low_bin_o       = low_q;
  assign high_bin_o      = high_q;
  assign bins_loaded_o   = loaded_q;
  assign empty_flag_o    = empty_q;
  assign overflow_flag_o = ovf_q;

  a_bins_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    bins_seen_q <= NUM_W'(MAX_BINS))
    else $error("bin counter past store depth");

  a_scan_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_SCAN |-> ({1'b0, scan_idx_q} < bins_seen_q))
    else $error("scan index beyond stored bins");

  a_finish_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_FINISH && out_free |=> bins_seen_q == '0 && total_q == '0 && out_valid_q)
    else $error("result transfer did not clear histogram state");

  a_scan_has_bins: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_PREP |-> bins_seen_q != '0)
    else $error("scan started with no stored bins");

endmodule

@@ sim/tb_top.sv @@
// Testbench for the histogram clip bounds block: directed table, random histograms, predictor.
module tb_top;
  import hcb_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int ROW_COUNT = 25;

  typedef struct packed {
    logic [7:0] low;
    logic [8:0] high;
    logic [8:0] loaded;
    logic       empty;
    logic       ovf;
  } clip_result_t;

  typedef struct packed {
    logic [23:0]  cnt;
    logic         last;
    logic         typed;
    clip_result_t want;
  } bin_row_t;

  localparam bin_row_t DIRECTED_BINS [ROW_COUNT] = '{
    {24'hFFFFFF, 1'b1, 1'b1, 8'd0, 9'd1, 9'd1, 1'b1, 1'b0},
    {24'h000000, 1'b1, 1'b1, 8'd0, 9'd1, 9'd1, 1'b1, 1'b0},
    {24'h000000, 1'b0, 1'b0, 28'd0},
    {24'h000000, 1'b0, 1'b0, 28'd0},
    {24'h000000, 1'b0, 1'b0, 28'd0},
    {24'h000000, 1'b1, 1'b1, 8'd0, 9'd1, 9'd4, 1'b1, 1'b0},
    {24'h000000, 1'b0, 1'b0, 28'd0},
    {24'hFFFFFF, 1'b1, 1'b0, 28'd0},
    {24'hFFFFFF, 1'b0, 1'b0, 28'd0},
    {24'hFFFFFF, 1'b0, 1'b0, 28'd0},
    {24'hFFFFFF, 1'b0, 1'b0, 28'd0},
    {24'hFFFFFF, 1'b1, 1'b0, 28'd0},
    {24'hAAAAAA, 1'b0, 1'b0, 28'd0},
    {24'h555555, 1'b0, 1'b0, 28'd0},
    {24'h000001, 1'b0, 1'b0, 28'd0},
    {24'h800000, 1'b0, 1'b0, 28'd0},
    {24'h7FFFFF, 1'b1, 1'b0, 28'd0},
    {24'h000001, 1'b0, 1'b0, 28'd0},
    {24'h000001, 1'b0, 1'b0, 28'd0},
    {24'h000001, 1'b0, 1'b0, 28'd0},
    {24'h000001, 1'b0, 1'b0, 28'd0},
    {24'h000001, 1'b1, 1'b0, 28'd0},
    {24'h000000, 1'b0, 1'b0, 28'd0},
    {24'h000100, 1'b0, 1'b0, 28'd0},
    {24'h000000, 1'b1, 1'b0, 28'd0}
  };

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic [23:0] bin_count_i = '0;
  logic        last_bin_i = 1'b0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [7:0]  low_bin_o;
  logic [8:0]  high_bin_o;
  logic [8:0]  bins_loaded_o;
  logic        empty_flag_o;
  logic        overflow_flag_o;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [15:0] clip_fraction_i = '0;

  logic [23:0]     hist_bins [MAX_BINS];
  int unsigned     hist_n = 0;
  longint unsigned hist_sum = 0;
  bit              hist_over = 1'b0;
  logic [15:0]     clip_q16 = CLIP_RESET;

  clip_result_t expected_bounds [$];
  int  errors = 0;
  int  items_sent = 0;
  int  results_seen = 0;
  int  cycles = 0;
  bit  src_eager = 1'b0;
  bit  sink_eager = 1'b0;

  histogram_clip_bounds_top DUT (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .in_valid_i(in_valid_i),
    .in_ready_o(in_ready_o),
    .bin_count_i(bin_count_i),
    .last_bin_i(last_bin_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .low_bin_o(low_bin_o),
    .high_bin_o(high_bin_o),
    .bins_loaded_o(bins_loaded_o),
    .empty_flag_o(empty_flag_o),
    .overflow_flag_o(overflow_flag_o),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .clip_fraction_i(clip_fraction_i)
  );

  always #4 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb_top NOT OK");
      $finish;
    end
  end

  // first bin past index 0 where the threshold test flips, 0 if none
  function automatic int unsigned crossing(int unsigned n, int unsigned skip,
                                           longint unsigned total, longint unsigned thr);
    longint unsigned acc;
    longint unsigned rhs;
    bit was;
    bit now;
    if (total == 0) return 0;
    rhs = thr * total;
    acc = (skip == 0) ? 64'd0 : 64'(hist_bins[0]);
    was = (acc << 16) >= rhs;
    for (int unsigned i = 1; i < n; i++) begin
      acc += (i == skip) ? 64'd0 : 64'(hist_bins[i]);
      now = (acc << 16) >= rhs;
      if (now != was) return i;
      was = now;
    end
    return 0;
  endfunction

  function automatic bit take_bin(logic [23:0] cnt, logic last, output clip_result_t r);
    int unsigned lo;
    int unsigned hi;
    longint unsigned tl;
    longint unsigned th;
    r = '0;
    if (hist_n < MAX_BINS) begin
      hist_bins[hist_n] = cnt;
      hist_n++;
      hist_sum += cnt;
    end else begin
      hist_over = 1'b1;
    end
    if (!last) return 1'b0;
    tl = hist_sum - hist_bins[0];
    th = hist_sum - hist_bins[hist_n - 1];
    lo = crossing(hist_n, 0, tl, longint'(clip_q16));
    hi = crossing(hist_n, hist_n - 1, th, 64'd65536 - longint'(clip_q16));
    r.low = (lo > 0) ? 8'(lo - 1) : 8'd0;
    r.high = 9'(hi + 1);
    r.loaded = 9'(hist_n);
    r.empty = (tl == 0 || th == 0);
    r.ovf = hist_over;
    hist_n = 0;
    hist_sum = 0;
    hist_over = 1'b0;
    return 1'b1;
  endfunction

  function automatic logic [23:0] draw_count(int style);
    case (style)
      0: return 24'($urandom);
      1: return 24'($urandom_range(0, 15));
      2: return ($urandom_range(0, 3) == 0) ? 24'($urandom) : 24'd0;
      default: return ($urandom_range(0, 1) == 1) ? 24'hFFFFFF : 24'($urandom_range(0, 3));
    endcase
  endfunction

  task automatic report(string what, longint unsigned got, longint unsigned want);
    errors++;
    if (errors <= 40) $display("mismatch %s: got %0d want %0d", what, got, want);
  endtask

  task automatic send_bin(input logic [23:0] cnt, input logic last, input logic typed,
                          input clip_result_t want);
    int gap;
    clip_result_t got;
    gap = src_eager ? 0 : $urandom_range(0, 18);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    bin_count_i <= cnt;
    last_bin_i <= last;
    do @(posedge clk_i); while (!in_ready_o);
    items_sent++;
    if (take_bin(cnt, last, got)) expected_bounds.push_back(typed ? want : got);
  endtask

  // drop valid, drain results, let any scan finish
  task automatic settle();
    in_valid_i <= 1'b0;
    while (expected_bounds.size() != 0) @(posedge clk_i);
    repeat (MAX_BINS + 8) @(posedge clk_i);
  endtask

  task automatic write_clip(input logic [15:0] v);
    cfg_valid_i <= 1'b1;
    clip_fraction_i <= v;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    clip_q16 = v;
  endtask

  task automatic check_bounds();
    clip_result_t want;
    if (expected_bounds.size() == 0) begin
      report("unexpected transfer, low_bin", low_bin_o, 0);
      return;
    end
    want = expected_bounds.pop_front();
    if (low_bin_o !== want.low) report("low_bin", low_bin_o, want.low);
    if (high_bin_o !== want.high) report("high_bin", high_bin_o, want.high);
    if (bins_loaded_o !== want.loaded) report("bins_loaded", bins_loaded_o, want.loaded);
    if (empty_flag_o !== want.empty) report("empty_flag", empty_flag_o, want.empty);
    if (overflow_flag_o !== want.ovf) report("overflow_flag", overflow_flag_o, want.ovf);
  endtask

  initial begin : sink
    int stall;
    while (!rst_ni) @(posedge clk_i);
    forever begin
      stall = sink_eager ? 0 : $urandom_range(0, 18);
      if (stall > 0) begin
        out_ready_i <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (!out_valid_o);
      check_bounds();
      results_seen++;
    end
  end

  initial begin : stimulus
    logic [15:0] clip_plan [6];
    logic [15:0] clip_pick;
    int hist_k;
    int size;
    int style;
    int phase;
    clip_plan = '{16'd0, 16'hFFFF, 16'h8000, 16'd1, 16'hFFFE, 16'd6554};
    hist_k = 0;
    phase = 0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    for (int i = 0; i < ROW_COUNT; i++)
      send_bin(DIRECTED_BINS[i].cnt, DIRECTED_BINS[i].last, DIRECTED_BINS[i].typed,
               DIRECTED_BINS[i].want);
    while (items_sent < 1150 || results_seen < 40) begin
      settle();
      if (phase < 6) clip_pick = clip_plan[phase];
      else if ($urandom_range(0, 1) == 1) clip_pick = 16'($urandom_range(0, 65535));
      else clip_pick = 16'($urandom_range(0, 4096));
      write_clip(clip_pick);
      sink_eager = (phase % 4 == 3);
      repeat (8) begin
        hist_k++;
        if (hist_k == 3) size = MAX_BINS;
        else if (hist_k == 17) size = $urandom_range(MAX_BINS + 1, MAX_BINS + 34);
        else if ($urandom_range(0, 15) == 0) size = $urandom_range(21, 64);
        else size = $urandom_range(1, 20);
        style = $urandom_range(0, 3);
        src_eager = ($urandom_range(0, 3) == 0);
        for (int b = 0; b < size; b++)
          send_bin(draw_count(style), b == size - 1, 1'b0, '0);
      end
      phase++;
    end
    settle();
    if (errors == 0) $display("tb_top OK");
    else $display("tb_top NOT OK");
    $finish;
  end

endmodule

@@ sim.f @@
sv/hcb_pkg.sv
sv/hcb_ram.sv
sv/hcb_scan.sv
sv/histogram_clip_bounds_top.sv
sim/tb_top.sv
